/* hw/rtl/mire_pkg.sv */
`timescale 1ns / 1ps
package mire_pkg;
    localparam int MAX_POINTS_DEF = 32;
    localparam int MIN_VALID      = 10;
    localparam int WIN_RESET      = 20;
    localparam int TS_W           = 32;
    localparam int WIN_W          = 6;
    localparam int M2_W           = 34;
    localparam int REM_W          = 35;
    localparam int DIV_STEPS      = 34;
    localparam logic [M2_W-1:0] RATE_NUM = M2_W'(131072000);
    localparam logic REG_WINDOW   = 1'b0;

    // per-cell control of the timestamp chain
    typedef struct packed {
        logic shift;
    } t_ts_ctl;

    // per-cell control of the sorting chain
    typedef struct packed {
        logic clear;
        logic shift;
    } t_sort_ctl;
endpackage

/* hw/rtl/mire_ts_cell.sv */
`timescale 1ns / 1ps
module mire_ts_cell
    import mire_pkg::*;
(
    input  logic            i_clk,
    input  t_ts_ctl         i_ctl,
    input  logic            i_load,
    input  logic [TS_W-1:0] i_load_val,
    input  logic [TS_W-1:0] i_nbr,
    output logic [TS_W-1:0] o_ts
);
    logic [TS_W-1:0] r_ts;
    logic [TS_W-1:0] n_ts;

    always_comb begin
        n_ts = r_ts;
        if (i_load) begin
            n_ts = i_load_val;
        end else if (i_ctl.shift) begin
            n_ts = i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts <= n_ts;
    end

    assign o_ts = r_ts;
endmodule

/* hw/rtl/mire_sort_cell.sv */
`timescale 1ns / 1ps
module mire_sort_cell
    import mire_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_sort_ctl       i_ctl,
    input  logic            i_in_valid,
    input  logic [TS_W-1:0] i_in_val,
    input  logic [TS_W-1:0] i_shift_val,
    output logic [TS_W-1:0] o_val,
    output logic            o_pass_valid,
    output logic [TS_W-1:0] o_pass_val
);
    logic            r_full;
    logic            r_pv;
    logic [TS_W-1:0] r_val;
    logic [TS_W-1:0] r_pval;

    // keep the smaller value, hand the larger one on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_full <= 1'b0;
            r_pv   <= 1'b0;
        end else if (i_ctl.shift) begin
            r_val <= i_shift_val;
            r_pv  <= 1'b0;
        end else begin
            r_pv <= 1'b0;
            if (i_in_valid) begin
                if (!r_full) begin
                    r_val  <= i_in_val;
                    r_full <= 1'b1;
                end else begin
                    r_pv   <= 1'b1;
                    r_val  <= (i_in_val < r_val) ? i_in_val : r_val;
                    r_pval <= (i_in_val < r_val) ? r_val : i_in_val;
                end
            end
        end
    end

    assign o_val        = r_val;
    assign o_pass_valid = r_pv;
    assign o_pass_val   = r_pval;
endmodule

/* hw/rtl/median_interval_rate_estimator_top.sv */
`timescale 1ns / 1ps
// a request runs drop/append, interval stream, sort settle, shift, median pick,
// divide and output; stale timestamps go one by one after the window register shrinks
// throughput: one request at a time, set by the interval stream, sort settle and the
// one-bit-per-cycle divider; fewer than ten held goes straight from append to output
// reset: synchronous active low, empties the window, window register back to 20
module median_interval_rate_estimator_top
    import mire_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input channel
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [31:0]     i_timestamp_ms,
    // output channel
    output logic            o_valid,
    input  logic            i_stall,
    output logic [31:0]     o_timestamp_echo,
    output logic [31:0]     o_rate_q16,
    output logic            o_rate_valid,
    // config port
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CNTW = (CW > 6) ? CW : 6;
    localparam int NS   = MAX_POINTS - 1;

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DROP   = 3'd1;
    localparam logic [2:0] ST_STREAM = 3'd2;
    localparam logic [2:0] ST_SETTLE = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_MED    = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]        r_state;
    logic [CW-1:0]     r_held;
    logic [CNTW-1:0]   r_cnt;
    logic [WIN_W-1:0]  r_win;
    logic [TS_W-1:0]   r_t;
    logic [M2_W-1:0]   r_m2;
    logic [M2_W-1:0]   r_num;
    logic [REM_W-1:0]  r_rem;
    logic [M2_W-1:0]   r_quo;
    logic              r_zero;
    logic              r_rv;

    logic              r_ov;
    logic [31:0]       r_o_ts;
    logic [31:0]       r_o_rate;
    logic              r_o_rv;

    // ---------------- configuration port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW) ? {26'd0, r_win} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_W'(WIN_RESET);
        end else if (cfg_wr && paddr[2] == REG_WINDOW) begin
            r_win <= pwdata[WIN_W-1:0];
        end
    end

    // effective window, clamped to [10, MAX_POINTS]
    logic [CNTW-1:0] win_ext;
    logic [CNTW-1:0] win_eff;
    always_comb begin
        win_ext = CNTW'(r_win);
        if (win_ext < CNTW'(MIN_VALID)) begin
            win_eff = CNTW'(MIN_VALID);
        end else if (win_ext > CNTW'(MAX_POINTS)) begin
            win_eff = CNTW'(MAX_POINTS);
        end else begin
            win_eff = win_ext;
        end
    end

    logic [CNTW-1:0] held_ext;
    logic [CNTW-1:0] n_iv;     // number of intervals
    logic [CNTW-1:0] shift_n;  // shifts to bring the lower middle to cell 0
    assign held_ext = CNTW'(r_held);
    assign n_iv     = held_ext - CNTW'(1);
    assign shift_n  = (n_iv - CNTW'(1)) >> 1;

    // ---------------- timestamp chain ----------------
    logic [TS_W-1:0] ts [MAX_POINTS];
    t_ts_ctl         ts_ctl;
    logic            app_en;
    assign ts_ctl.shift = (r_state == ST_DROP && held_ext >= win_eff) ||
                          (r_state == ST_STREAM);
    assign app_en = (r_state == ST_DROP) && (held_ext < win_eff);

    for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_ts
        logic [TS_W-1:0] nbr;
        // during the interval stream the held part of the chain rotates
        assign nbr = (r_state == ST_STREAM && r_held == CW'(gi + 1)) ? ts[0]
                   : ts[(gi + 1) % MAX_POINTS];
        mire_ts_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ts_ctl),
            .i_load     (app_en && r_held == CW'(gi)),
            .i_load_val (r_t),
            .i_nbr      (nbr),
            .o_ts       (ts[gi])
        );
    end

    // ---------------- sorting chain ----------------
    logic [TS_W-1:0] s_val [NS];
    logic            s_pv  [NS];
    logic [TS_W-1:0] s_pvl [NS];
    t_sort_ctl       s_ctl;
    logic            feed_v;
    logic [TS_W-1:0] feed_iv;
    assign s_ctl.clear = (r_state == ST_IDLE);
    assign s_ctl.shift = (r_state == ST_SHIFT) && (r_cnt < shift_n);
    assign feed_v  = (r_state == ST_STREAM) && (r_cnt < n_iv);
    assign feed_iv = ts[1] - ts[0];   // modulo 2^32, right across timer wrap

    for (genvar gs = 0; gs < NS; gs++) begin : g_sort
        logic            in_v;
        logic [TS_W-1:0] in_d;
        logic [TS_W-1:0] sh_d;
        if (gs == 0) begin : g_first
            assign in_v = feed_v;
            assign in_d = feed_iv;
        end else begin : g_rest
            assign in_v = s_pv[gs-1];
            assign in_d = s_pvl[gs-1];
        end
        if (gs == NS - 1) begin : g_last
            assign sh_d = '0;
        end else begin : g_mid
            assign sh_d = s_val[gs+1];
        end
        mire_sort_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (s_ctl),
            .i_in_valid   (in_v),
            .i_in_val     (in_d),
            .i_shift_val  (sh_d),
            .o_val        (s_val[gs]),
            .o_pass_valid (s_pv[gs]),
            .o_pass_val   (s_pvl[gs])
        );
    end

    // ---------------- divider step ----------------
    logic [REM_W-1:0] rem_sh;
    logic             rem_ge;
    assign rem_sh = {r_rem[REM_W-2:0], r_num[M2_W-1]};
    assign rem_ge = rem_sh >= REM_W'(r_m2);

    // ---------------- sequencer ----------------
    logic accept;
    logic out_free;
    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_t     <= i_timestamp_ms;
                        r_state <= ST_DROP;
                    end
                end
                ST_DROP: begin
                    // drop oldest until there is room, then append
                    if (held_ext >= win_eff) begin
                        r_held <= r_held - CW'(1);
                    end else begin
                        r_held <= r_held + CW'(1);
                        r_cnt  <= '0;
                        if (held_ext + CNTW'(1) < CNTW'(MIN_VALID)) begin
                            r_rv    <= 1'b0;
                            r_quo   <= '0;
                            r_zero  <= 1'b0;
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_STREAM;
                        end
                    end
                end
                ST_STREAM: begin
                    if (r_cnt == n_iv) begin
                        r_cnt   <= '0;
                        r_state <= ST_SETTLE;
                    end else begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                ST_SETTLE: begin
                    if (r_cnt == CNTW'(NS)) begin
                        r_cnt   <= '0;
                        r_state <= ST_SHIFT;
                    end else begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                ST_SHIFT: begin
                    if (r_cnt >= shift_n) begin
                        r_state <= ST_MED;
                    end else begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                ST_MED: begin
                    if (n_iv[0]) begin
                        r_m2 <= {1'b0, s_val[0], 1'b0};
                    end else begin
                        r_m2 <= M2_W'(s_val[0]) + M2_W'(s_val[1]);
                    end
                    r_rv  <= 1'b1;
                    r_cnt <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        // load numerator for round-to-nearest
                        r_num  <= RATE_NUM + (r_m2 >> 1);
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_zero <= (r_m2 == '0);
                        r_cnt  <= r_cnt + CNTW'(1);
                    end else begin
                        r_num <= r_num << 1;
                        r_rem <= rem_ge ? rem_sh - REM_W'(r_m2) : rem_sh;
                        r_quo <= {r_quo[M2_W-2:0], rem_ge};
                        if (r_cnt == CNTW'(DIV_STEPS)) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_cnt <= r_cnt + CNTW'(1);
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (r_ov && !i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_o_ts   <= r_t;
            r_o_rate <= r_zero ? 32'hFFFF_FFFF : r_quo[31:0];
            r_o_rv   <= r_rv;
        end
    end

    assign o_valid          = r_ov;
    assign o_timestamp_echo = r_o_ts;
    assign o_rate_q16       = r_o_rate;
    assign o_rate_valid     = r_o_rv;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held_ext <= CNTW'(MAX_POINTS))
        else $error("held count above depth");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_DROP)
        else $error("request accepted without starting");
    a_valid_enough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STREAM) |-> held_ext >= CNTW'(MIN_VALID))
        else $error("median started with too few timestamps");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !out_free) |=> r_state == ST_OUT)
        else $error("result lost while output busy");
`endif
endmodule
